// File: design/ihl_pkg.sv
package ihl_pkg;

    localparam int DEFAULT_MAX_REGIONS = 500;
    localparam int IMAGE_AW            = 16;
    localparam int BYTE_W              = 8;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_SYNTAX   = 3'd1;
    localparam logic [2:0] ERR_CHECKSUM = 3'd2;
    localparam logic [2:0] ERR_OVER64K  = 3'd3;
    localparam logic [2:0] ERR_UNSUP    = 3'd4;
    localparam logic [2:0] ERR_REGIONS  = 3'd5;

    localparam logic [7:0] KIND_DATA    = 8'd0;
    localparam logic [7:0] KIND_EOF     = 8'd1;
    localparam logic [7:0] KIND_SEGMENT = 8'd2;
    localparam logic [7:0] KIND_LAST    = 8'd5;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic                en;
        logic [IMAGE_AW-1:0] addr;
        logic [BYTE_W-1:0]   data;
    } wr_req_t;

endpackage

// File: design/ihl_ram.sv
module ihl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/ihl_parser.sv
module ihl_parser import ihl_pkg::*; #(
    parameter int MAX_REGIONS = DEFAULT_MAX_REGIONS,
    parameter int CW          = $clog2(MAX_REGIONS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          feed,
    input  logic [7:0]    char_code,
    output wr_req_t       wr,
    output logic [2:0]    error_code,
    output logic          load_done,
    output logic [15:0]   image_start,
    output logic [16:0]   image_size,
    output logic [CW-1:0] region_total
);

    typedef enum logic [1:0] {PH_COLON, PH_HI, PH_LO, PH_SKIP} phase_t;

    phase_t        phase_reg, phase_next;
    logic [3:0]    nib_reg, nib_next;
    logic [8:0]    idx_reg, idx_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    sum_reg, sum_next;
    logic [15:0]   addr_reg, addr_next;
    logic [7:0]    kind_reg, kind_next;
    logic [19:0]   seg_reg, seg_next;
    logic [20:0]   prev_reg, prev_next;
    logic [15:0]   open_reg, open_next;
    logic [15:0]   low_reg, low_next;
    logic [15:0]   hs_reg, hs_next;
    logic [16:0]   he_reg, he_next;
    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    err_reg, err_next;
    logic          done_reg, done_next;
    logic [15:0]   dw_reg, dw_next;

    logic          dig_ok;
    logic [3:0]    dig;
    logic [7:0]    byte_v;
    logic [8:0]    len_end;
    logic [20:0]   base;
    logic [21:0]   last;
    logic [CW-1:0] count_inc;
    logic          ok;

    always_comb
    begin
        dig_ok = 1'b1;
        dig    = 4'd0;
        if (char_code >= 8'h30 && char_code <= 8'h39)
        begin
            dig = 4'(char_code - 8'h30);
        end
        else if (char_code >= 8'h41 && char_code <= 8'h46)
        begin
            dig = 4'(char_code - 8'h37);
        end
        else
        begin
            dig_ok = 1'b0;
        end
    end

    assign byte_v    = {nib_reg, dig};
    assign len_end   = {1'b0, len_reg} + 9'd4;
    assign base      = {5'd0, addr_reg} + {1'b0, seg_reg};
    assign last      = {1'b0, base} + {14'd0, len_reg} - 22'd1;
    assign count_inc = count_reg + CW'(1);

    always_comb
    begin
        phase_next = phase_reg;
        nib_next   = nib_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        addr_next  = addr_reg;
        kind_next  = kind_reg;
        seg_next   = seg_reg;
        prev_next  = prev_reg;
        open_next  = open_reg;
        low_next   = low_reg;
        hs_next    = hs_reg;
        he_next    = he_reg;
        count_next = count_reg;
        err_next   = err_reg;
        done_next  = done_reg;
        dw_next    = dw_reg;
        ok         = 1'b1;
        wr.en      = 1'b0;
        wr.addr    = addr_reg + seg_reg[15:0] + {8'd0, 8'(idx_reg - 9'd4)};
        wr.data    = byte_v;

        if (feed && err_reg == ERR_NONE && !done_reg)
        begin
            unique case (phase_reg)
                PH_COLON:
                begin
                    if (char_code == CHAR_COLON)
                    begin
                        phase_next = PH_HI;
                        idx_next   = 9'd0;
                        sum_next   = 8'd0;
                    end
                    else
                    begin
                        err_next = ERR_SYNTAX;
                    end
                end
                PH_SKIP:
                begin
                    if (char_code == CHAR_LF)
                    begin
                        phase_next = PH_COLON;
                    end
                end
                PH_HI, PH_LO:
                begin
                    if (!dig_ok)
                    begin
                        err_next = (idx_reg == 9'd0) ? ERR_SYNTAX : ERR_CHECKSUM;
                    end
                    else if (phase_reg == PH_HI)
                    begin
                        nib_next   = dig;
                        phase_next = PH_LO;
                    end
                    else
                    begin
                        sum_next = sum_reg + byte_v;
                        if (idx_reg == 9'd0)
                        begin
                            len_next = byte_v;
                        end
                        else if (idx_reg == 9'd1)
                        begin
                            addr_next = {byte_v, 8'd0};
                        end
                        else if (idx_reg == 9'd2)
                        begin
                            addr_next = {addr_reg[15:8], byte_v};
                        end
                        else if (idx_reg == 9'd3)
                        begin
                            kind_next = byte_v;
                        end
                        else if (idx_reg < len_end)
                        begin
                            wr.en   = (kind_reg == KIND_DATA);
                            dw_next = {dw_reg[7:0], byte_v};
                        end

                        if (idx_reg >= 9'd4 && idx_reg == len_end)
                        begin
                            // record end
                            if (sum_next != 8'd0)
                            begin
                                err_next = ERR_CHECKSUM;
                            end
                            else if (kind_reg > KIND_LAST)
                            begin
                                err_next = ERR_SYNTAX;
                            end
                            else if (kind_reg > KIND_SEGMENT)
                            begin
                                err_next = ERR_UNSUP;
                            end
                            else
                            begin
                                if (kind_reg == KIND_SEGMENT)
                                begin
                                    if (len_reg != 8'd2)
                                    begin
                                        err_next = ERR_SYNTAX;
                                        ok       = 1'b0;
                                    end
                                    else
                                    begin
                                        seg_next = {dw_reg, 4'd0};
                                    end
                                end
                                else if (kind_reg == KIND_DATA && len_reg != 8'd0)
                                begin
                                    if (last > 22'h00FFFF)
                                    begin
                                        err_next = ERR_OVER64K;
                                        ok       = 1'b0;
                                    end
                                    else
                                    begin
                                        if (prev_reg != base)
                                        begin
                                            if (count_reg != '0 && open_reg >= hs_reg)
                                            begin
                                                hs_next = open_reg;
                                                he_next = prev_reg[16:0];
                                            end
                                            open_next = base[15:0];
                                            if (base[15:0] < low_reg)
                                            begin
                                                low_next = base[15:0];
                                            end
                                            count_next = count_inc;
                                            if (count_inc >= CW'(MAX_REGIONS))
                                            begin
                                                err_next = ERR_REGIONS;
                                                ok       = 1'b0;
                                            end
                                        end
                                        if (ok)
                                        begin
                                            prev_next = base + {13'd0, len_reg};
                                        end
                                    end
                                end
                                if (ok)
                                begin
                                    if (kind_reg == KIND_EOF)
                                    begin
                                        if (count_reg != '0 && open_reg >= hs_reg)
                                        begin
                                            hs_next = open_reg;
                                            he_next = prev_reg[16:0];
                                        end
                                        done_next = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_SKIP;
                                    end
                                end
                            end
                        end
                        else
                        begin
                            idx_next   = idx_reg + 9'd1;
                            phase_next = PH_HI;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_COLON;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COLON;
            nib_reg   <= '0;
            idx_reg   <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            addr_reg  <= '0;
            kind_reg  <= '0;
            seg_reg   <= '0;
            prev_reg  <= 21'h0FFFFE;
            open_reg  <= '0;
            low_reg   <= 16'hFFFF;
            hs_reg    <= '0;
            he_reg    <= '0;
            count_reg <= '0;
            err_reg   <= ERR_NONE;
            done_reg  <= 1'b0;
            dw_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            nib_reg   <= nib_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            addr_reg  <= addr_next;
            kind_reg  <= kind_next;
            seg_reg   <= seg_next;
            prev_reg  <= prev_next;
            open_reg  <= open_next;
            low_reg   <= low_next;
            hs_reg    <= hs_next;
            he_reg    <= he_next;
            count_reg <= count_next;
            err_reg   <= err_next;
            done_reg  <= done_next;
            dw_reg    <= dw_next;
        end
    end

    assign error_code   = err_reg;
    assign load_done    = done_reg;
    assign image_start  = (done_reg && count_reg != '0) ? low_reg : 16'd0;
    assign image_size   = (done_reg && count_reg != '0) ? he_reg : 17'd0;
    assign region_total = count_reg;

`ifndef SYNTHESIS
    a_err_latched: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ERR_NONE |=> err_reg == $past(err_reg))
        else $error("error code changed after latching");
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg && $stable(count_reg))
        else $error("state moved after end of file");
    a_done_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        !(done_reg && err_reg != ERR_NONE))
        else $error("done together with error");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_REGIONS))
        else $error("region count beyond limit");
    a_wr_only_feed: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> feed && phase_reg == PH_LO && kind_reg == KIND_DATA)
        else $error("image write outside a data byte");
`endif

endmodule

// File: design/intel_hex_image_loader.sv
// Latency: a request's response is offered on the cycle after acceptance.
// Throughput: one request per cycle while req_stall is low; one character or one image read each.
// A read is served by the registered port of the 64 KiB image RAM.
// Reset (rst_n, async, low) clears parser state, errors and region tracking.
// The image RAM is not cleared; unwritten bytes read as undefined.
module intel_hex_image_loader import ihl_pkg::*; #(
    parameter int MAX_REGIONS = DEFAULT_MAX_REGIONS,
    parameter int CW          = $clog2(MAX_REGIONS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  logic          opcode,
    input  logic [7:0]    char_code,
    input  logic [15:0]   read_address,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output logic [2:0]    error_code,
    output logic          load_done,
    output logic [15:0]   image_start,
    output logic [16:0]   image_size,
    output logic [CW-1:0] region_total,
    output logic [7:0]    read_byte
);

    logic       accept;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       rd_op_reg;
    wr_req_t    wr;
    logic [7:0] rd_data;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    ihl_parser #(
        .MAX_REGIONS (MAX_REGIONS),
        .CW          (CW)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .feed         (accept && opcode == OP_FEED),
        .char_code    (char_code),
        .wr           (wr),
        .error_code   (error_code),
        .load_done    (load_done),
        .image_start  (image_start),
        .image_size   (image_size),
        .region_total (region_total)
    );

    ihl_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (1 << IMAGE_AW)
    ) u_image (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (accept && opcode == OP_READ),
        .rd_addr (read_address),
        .rd_data (rd_data)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_op_reg <= opcode;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign read_byte = (rd_op_reg == OP_READ) ? rd_data : 8'd0;

endmodule

// File: verif/intel_hex_image_loader_checker.sv
`timescale 1ns / 1ps

module intel_hex_image_loader_checker import ihl_pkg::*; #(
    parameter int MAX_REGIONS = DEFAULT_MAX_REGIONS,
    parameter int CW          = $clog2(MAX_REGIONS + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  logic          opcode,
    input  logic [7:0]    char_code,
    input  logic [15:0]   read_address,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  logic [2:0]    error_code,
    input  logic          load_done,
    input  logic [15:0]   image_start,
    input  logic [16:0]   image_size,
    input  logic [CW-1:0] region_total,
    input  logic [7:0]    read_byte,
    output int            outstanding,
    output int            fail_count
);

    typedef enum logic [1:0] {WAIT_COLON, HI_DIGIT, LO_DIGIT, SKIP_LINE} parse_phase_t;

    typedef struct {
        logic [2:0]  err;
        logic        done;
        logic [15:0] start;
        logic [16:0] size;
        logic [16:0] total;
        logic [7:0]  rbyte;
    } load_status_t;

    load_status_t status_q[$];

    logic [7:0]   image [0:65535];
    parse_phase_t phase;
    logic [3:0]   nib;
    logic [8:0]   idx;
    logic [7:0]   rlen;
    logic [7:0]   sum;
    logic [15:0]  raddr;
    logic [7:0]   kind;
    logic [19:0]  seg;
    logic [20:0]  prev_end;
    logic [15:0]  open_start;
    logic [15:0]  low_start;
    logic [15:0]  hi_start;
    logic [16:0]  hi_end;
    int           rcount;
    logic [2:0]   err;
    logic         done;
    logic [15:0]  dword;

    function automatic int hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function void close_open_region();
        if (open_start >= hi_start)
        begin
            hi_start = open_start;
            hi_end   = prev_end[16:0];
        end
    endfunction

    function void end_of_record();
        int base;
        if (sum != 8'd0)
        begin
            err = ERR_CHECKSUM;
            return;
        end
        if (kind > KIND_LAST)
        begin
            err = ERR_SYNTAX;
            return;
        end
        if (kind > KIND_SEGMENT)
        begin
            err = ERR_UNSUP;
            return;
        end
        if (kind == KIND_SEGMENT)
        begin
            if (rlen != 8'd2)
            begin
                err = ERR_SYNTAX;
                return;
            end
            seg = {dword, 4'h0};
        end
        else if (kind == KIND_DATA && rlen != 8'd0)
        begin
            base = int'(raddr) + int'(seg);
            if (base + int'(rlen) - 1 > 'hffff)
            begin
                err = ERR_OVER64K;
                return;
            end
            if (int'(prev_end) != base)
            begin
                if (rcount != 0)
                    close_open_region();
                open_start = base[15:0];
                if (base < int'(low_start))
                    low_start = base[15:0];
                rcount++;
                if (rcount >= MAX_REGIONS)
                begin
                    err = ERR_REGIONS;
                    return;
                end
            end
            prev_end = 21'(base + int'(rlen));
        end
        if (kind == KIND_EOF)
        begin
            if (rcount != 0)
                close_open_region();
            done = 1'b1;
            return;
        end
        phase = SKIP_LINE;
    endfunction

    function void take_char(logic [7:0] c);
        int         v;
        int         a;
        logic [7:0] b;
        if (err != ERR_NONE || done)
            return;
        if (phase == WAIT_COLON)
        begin
            if (c == CHAR_COLON)
            begin
                phase = HI_DIGIT;
                idx   = 9'd0;
                sum   = 8'd0;
            end
            else
                err = ERR_SYNTAX;
            return;
        end
        if (phase == SKIP_LINE)
        begin
            if (c == CHAR_LF)
                phase = WAIT_COLON;
            return;
        end
        v = hex_value(c);
        if (v < 0)
        begin
            err = (idx == 9'd0) ? ERR_SYNTAX : ERR_CHECKSUM;
            return;
        end
        if (phase == HI_DIGIT)
        begin
            nib   = v[3:0];
            phase = LO_DIGIT;
            return;
        end
        b   = {nib, v[3:0]};
        sum = sum + b;
        if (idx == 9'd0)
            rlen = b;
        else if (idx == 9'd1)
            raddr = {b, 8'h00};
        else if (idx == 9'd2)
            raddr[7:0] = b;
        else if (idx == 9'd3)
            kind = b;
        else if (int'(idx) < int'(rlen) + 4)
        begin
            if (kind == KIND_DATA)
            begin
                a = int'(raddr) + int'(seg) + int'(idx) - 4;
                image[a[15:0]] = b;
            end
            dword = {dword[7:0], b};
        end
        if (idx >= 9'd4 && int'(idx) == int'(rlen) + 4)
        begin
            end_of_record();
            return;
        end
        idx   = idx + 9'd1;
        phase = HI_DIGIT;
    endfunction

    task automatic compare_field(input string name, input logic [16:0] want,
                                 input logic [16:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        load_status_t s;
        load_status_t w;
        if (!rst_n)
        begin
            phase      = WAIT_COLON;
            nib        = '0;
            idx        = '0;
            rlen       = '0;
            sum        = '0;
            raddr      = '0;
            kind       = '0;
            seg        = '0;
            prev_end   = 21'hffffe;
            open_start = '0;
            low_start  = 16'hffff;
            hi_start   = '0;
            hi_end     = '0;
            rcount     = 0;
            err        = ERR_NONE;
            done       = 1'b0;
            dword      = '0;
            status_q.delete();
            outstanding = 0;
            fail_count  = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (status_q.size() == 0)
                begin
                    $display("%0t: response with no request waiting", $time);
                    fail_count++;
                end
                else
                begin
                    w = status_q.pop_front();
                    compare_field("error_code", 17'(w.err), 17'(error_code));
                    compare_field("load_done", 17'(w.done), 17'(load_done));
                    compare_field("image_start", 17'(w.start), 17'(image_start));
                    compare_field("image_size", w.size, image_size);
                    compare_field("region_total", w.total, 17'(region_total));
                    compare_field("read_byte", 17'(w.rbyte), 17'(read_byte));
                end
            end
            if (req_valid && !req_stall)
            begin
                s.rbyte = 8'd0;
                if (opcode == OP_READ)
                    s.rbyte = image[read_address];
                else
                    take_char(char_code);
                s.err   = err;
                s.done  = done;
                s.start = (done && rcount != 0) ? low_start : 16'd0;
                s.size  = (done && rcount != 0) ? hi_end : 17'd0;
                s.total = 17'(rcount);
                status_q.push_back(s);
            end
            outstanding = status_q.size();
        end
    end

endmodule

// File: verif/intel_hex_image_loader_tb.sv
`timescale 1ns / 1ps

module intel_hex_image_loader_tb;
    import ihl_pkg::*;

    localparam int REGION_LIMIT = 24;
    localparam int CW           = $clog2(REGION_LIMIT + 1);
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 700;

    typedef logic [7:0] byte_q_t[$];

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    logic          opcode;
    logic [7:0]    char_code;
    logic [15:0]   read_address;
    logic          rsp_valid;
    logic          rsp_stall;
    logic [2:0]    error_code;
    logic          load_done;
    logic [15:0]   image_start;
    logic [16:0]   image_size;
    logic [CW-1:0] region_total;
    logic [7:0]    read_byte;
    int            outstanding;
    int            fail_count;

    bit            written [0:65535];
    int            written_list[$];
    int            seg_base;
    int            prev_end;
    int            regions;
    int            sent;
    int            records;
    int            cycles;
    bit            hold_req;
    logic [7:0]    csum;
    string         ending;

    intel_hex_image_loader #(.MAX_REGIONS(REGION_LIMIT)) DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .opcode(opcode), .char_code(char_code), .read_address(read_address),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .error_code(error_code), .load_done(load_done),
        .image_start(image_start), .image_size(image_size),
        .region_total(region_total), .read_byte(read_byte)
    );

    intel_hex_image_loader_checker #(.MAX_REGIONS(REGION_LIMIT)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .opcode(opcode), .char_code(char_code), .read_address(read_address),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .error_code(error_code), .load_done(load_done),
        .image_start(image_start), .image_size(image_size),
        .region_total(region_total), .read_byte(read_byte),
        .outstanding(outstanding), .fail_count(fail_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("intel_hex_image_loader_tb: errors");
                $finish;
            end
        end
    end

    // response side: quiet stretches, short and occasional long stalls, one long hold
    initial
    begin
        int stall_left;
        int n;
        rsp_stall  = 1'b0;
        stall_left = 0;
        n          = 0;
        forever
        begin
            @(negedge clk);
            n++;
            if (hold_req)
            begin
                rsp_stall <= 1'b1;
                repeat (150) @(negedge clk);
                hold_req = 1'b0;
                rsp_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if ((n / 200) % 3 == 0)
                rsp_stall <= 1'b0;
            else if ($urandom_range(9) < 3)
            begin
                stall_left = ($urandom_range(99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(8, 30);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    task automatic put_request(input logic op, input logic [7:0] ch, input logic [15:0] ad);
        int gap;
        gap = 0;
        if ((sent / 150) % 3 != 1 && $urandom_range(9) < 3)
            gap = ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid    <= 1'b1;
        opcode       <= op;
        char_code    <= ch;
        read_address <= ad;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic read_back();
        if (written_list.size() != 0)
            put_request(OP_READ, 8'($urandom),
                        16'(written_list[$urandom_range(written_list.size() - 1)]));
    endtask

    task automatic feed(input logic [7:0] c);
        if ($urandom_range(7) == 0)
            read_back();
        put_request(OP_FEED, c, 16'($urandom));
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'("0" + n) : 8'("A" + n - 10);
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        feed(hex_char(b[7:4]));
        feed(hex_char(b[3:0]));
        csum = csum + b;
    endtask

    // trailing text after a record is skipped up to LF
    task automatic line_end();
        int r;
        int k;
        logic [7:0] c;
        r = $urandom_range(9);
        if (r < 3)
            feed(8'h0D);
        else if (r < 5)
        begin
            for (k = 0; k < $urandom_range(1, 4); k++)
            begin
                c = 8'($urandom);
                if (c == CHAR_LF)
                    c = 8'hFF;
                feed(c);
            end
        end
        feed(CHAR_LF);
    endtask

    task automatic send_record(input logic [7:0] kind, input logic [7:0] len,
                               input logic [15:0] addr, input byte_q_t dat,
                               input bit bad_sum);
        csum = 8'd0;
        feed(CHAR_COLON);
        emit_byte(len);
        emit_byte(addr[15:8]);
        emit_byte(addr[7:0]);
        emit_byte(kind);
        foreach (dat[i])
            emit_byte(dat[i]);
        emit_byte(8'(-csum) + 8'(bad_sum));
        line_end();
        records++;
    endtask

    function automatic byte_q_t random_bytes(input int len);
        byte_q_t q;
        for (int i = 0; i < len; i++)
            q.push_back(8'($urandom));
        return q;
    endfunction

    task automatic data_record(input int base, input byte_q_t dat);
        int len;
        len = dat.size();
        send_record(KIND_DATA, 8'(len), 16'(base - seg_base), dat, 1'b0);
        if (base != prev_end)
            regions++;
        prev_end = base + len;
        for (int a = base; a < base + len; a++)
            if (!written[a])
            begin
                written[a] = 1'b1;
                written_list.push_back(a);
            end
    endtask

    task automatic segment_record(input logic [15:0] val);
        byte_q_t d;
        d = {val[15:8], val[7:0]};
        send_record(KIND_SEGMENT, 8'd2, 16'($urandom), d, 1'b0);
        seg_base = int'(val) << 4;
    endtask

    task automatic random_record();
        int r;
        int len;
        r = $urandom_range(99);
        if (r < 8)
        begin
            segment_record(($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(0, 'h0F00)));
            return;
        end
        len = ($urandom_range(9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 32);
        if (r >= 12 && $urandom_range(3) != 0 && prev_end >= seg_base
            && prev_end + len <= 'h10000)
            data_record(prev_end, random_bytes(len));
        else if (r >= 12 && regions < REGION_LIMIT - 2)
            data_record($urandom_range(seg_base, 'h10000 - len), random_bytes(len));
        else
            send_record(KIND_DATA, 8'd0, 16'($urandom), random_bytes(0), 1'b0);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic finish_stream();
        int      k;
        int      base;
        byte_q_t d;
        case ($urandom_range(9))
            0:
            begin
                ending = "end-of-file record";
                send_record(KIND_EOF, 8'd0, 16'd0, random_bytes(0), 1'b0);
            end
            1:
            begin
                ending = "bad checksum";
                send_record(KIND_DATA, 8'd2, 16'($urandom), random_bytes(2), 1'b1);
            end
            2:
            begin
                ending = "lower-case count digit";
                feed(CHAR_COLON);
                feed("a");
            end
            3:
            begin
                ending = "non-hex digit in body";
                feed(CHAR_COLON);
                feed("0");
                feed("1");
                feed("G");
            end
            4:
            begin
                ending = "unknown record type";
                send_record(8'($urandom_range(6, 255)), 8'd0, 16'd0, random_bytes(0), 1'b0);
            end
            5:
            begin
                ending = "unsupported record type";
                send_record(8'($urandom_range(3, 5)), 8'd0, 16'd0, random_bytes(0), 1'b0);
            end
            6:
            begin
                ending = "segment record of wrong length";
                d = random_bytes($urandom_range(0, 1) ? 1 : 3);
                send_record(KIND_SEGMENT, 8'(d.size()), 16'd0, d, 1'b0);
            end
            7:
            begin
                ending = "data past 64K";
                send_record(KIND_DATA, 8'd32, 16'hFFF0, random_bytes(32), 1'b0);
            end
            8:
            begin
                ending = "region overflow";
                while (regions < REGION_LIMIT)
                begin
                    base = $urandom_range(seg_base, 'hFFFF);
                    if (base != prev_end)
                    begin
                        d = random_bytes(1);
                        data_record(base, d);
                    end
                end
            end
            default:
            begin
                ending = "missing colon";
                feed("X");
            end
        endcase
        for (k = 0; k < 12; k++)
        begin
            read_back();
            put_request(OP_FEED, 8'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        byte_q_t d;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        opcode       = OP_FEED;
        char_code    = 8'd0;
        read_address = 16'd0;
        hold_req     = 1'b0;
        seg_base     = 0;
        prev_end     = 'hffffe;
        regions      = 0;
        sent         = 0;
        records      = 0;
        ending       = "";
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: address extremes, segment base, repeated region start
        d = {8'h00, 8'hFF};
        data_record(0, d);
        put_request(OP_READ, 8'h00, 16'h0000);
        put_request(OP_READ, 8'hFF, 16'h0001);
        d = {8'hA5};
        data_record('hFFFF, d);
        put_request(OP_READ, 8'h5A, 16'hFFFF);
        segment_record(16'h0100);
        data_record('h1000, random_bytes(3));
        segment_record(16'h0000);
        data_record(0, random_bytes(1));
        data_record('h8000, random_bytes(255));
        drain();

        while (sent < ITEM_TARGET - 60)
        begin
            if (!hold_req && sent > 350 && sent < 360)
                hold_req = 1'b1;
            random_record();
        end
        finish_stream();
        drain();
        repeat (5) @(posedge clk);
        $display("%0d requests, %0d records, %0d regions, %0d image bytes written",
                 sent, records, regions, written_list.size());
        $display("stream ended with: %s", ending);
        if (fail_count == 0 && outstanding == 0)
            $display("intel_hex_image_loader_tb: clean");
        else
            $display("intel_hex_image_loader_tb: errors");
        $finish;
    end

endmodule

// File: filelist.f
design/ihl_pkg.sv
design/ihl_ram.sv
design/ihl_parser.sv
design/intel_hex_image_loader.sv
verif/intel_hex_image_loader_checker.sv
verif/intel_hex_image_loader_tb.sv
